// ----- hw/rtl/dnsa_pkg.sv -----
// Shared types and constants for the DNS answer address extractor.
// No dependencies; imported by the parser, the top level and the checker.
`timescale 1ns / 1ps

package dnsa_pkg;

   // Parser phases, one-hot
   typedef enum logic [5:0] {
      PH_HEADER  = 6'b000001,
      PH_QNAME   = 6'b000010,
      PH_QFIXED  = 6'b000100,
      PH_RRFIXED = 6'b001000,
      PH_RRDATA  = 6'b010000,
      PH_DONE    = 6'b100000
   } phase_type;

   // Last counter value of each fixed-size field group
   localparam logic [15:0] HDR_LAST     = 16'd11;
   localparam logic [15:0] QFIXED_LAST  = 16'd3;
   localparam logic [15:0] RRFIXED_LAST = 16'd11;

   // Header and record byte positions
   localparam logic [15:0] HDR_ANCOUNT_HI = 16'd6;
   localparam logic [15:0] HDR_ANCOUNT_LO = 16'd7;
   localparam logic [15:0] RR_TYPE_HI     = 16'd2;
   localparam logic [15:0] RR_TYPE_LO     = 16'd3;
   localparam logic [15:0] RR_RDLEN_HI    = 16'd10;
   localparam logic [15:0] RR_RDLEN_LO    = 16'd11;

   localparam logic [15:0] TYPE_A    = 16'd1;
   localparam logic [15:0] TYPE_AAAA = 16'd28;

   localparam logic [15:0] A_DATA_BYTES    = 16'd4;
   localparam logic [15:0] AAAA_DATA_BYTES = 16'd16;

   // Upper half of address_low for an IPv4-mapped address
   localparam logic [31:0] V4_MAP_HI = 32'h0000FFFF;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_V4   = 2'd1;
   localparam logic [1:0] KIND_V6   = 2'd2;

   typedef struct packed {
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic [1:0]  found_kind;
      logic        truncated;
   } result_type;

endpackage

// ----- hw/rtl/dnsa_parser.sv -----
// Byte-wise DNS response parser: phase, counters, candidate and committed address.
// Depends on dnsa_pkg. Result reflects the state after the current byte.
`timescale 1ns / 1ps

module dnsa_parser import dnsa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] msg_byte,
   input  logic       last_byte,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] ans_ff, ans_in;
   logic [15:0] kind_ff, kind_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  cand_ff [16];
   logic [7:0]  cand_in [16];
   logic [63:0] com_hi_ff, com_hi_in;
   logic [63:0] com_lo_ff, com_lo_in;
   logic [1:0]  com_kind_ff, com_kind_in;

   logic        finish;
   logic [15:0] cnt_inc;
   logic [15:0] len_new;
   logic [63:0] cand_hi, cand_lo;
   logic [31:0] cand_v4;

   always_comb begin
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      ans_in      = ans_ff;
      kind_in     = kind_ff;
      len_in      = len_ff;
      cand_in     = cand_ff;
      com_hi_in   = com_hi_ff;
      com_lo_in   = com_lo_ff;
      com_kind_in = com_kind_ff;
      finish      = 1'b0;
      cnt_inc     = cnt_ff + 16'd1;
      len_new     = {len_ff[15:8], msg_byte};

      unique case (phase_ff)
         PH_HEADER: begin
            if (cnt_ff == HDR_ANCOUNT_HI) ans_in[15:8] = msg_byte;
            if (cnt_ff == HDR_ANCOUNT_LO) ans_in[7:0] = msg_byte;
            if (cnt_ff >= HDR_LAST) begin
               cnt_in   = '0;
               phase_in = (ans_ff == '0) ? PH_DONE : PH_QNAME;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_QNAME: begin
            if (msg_byte == 8'd0) begin
               cnt_in   = '0;
               phase_in = PH_QFIXED;
            end
         end
         PH_QFIXED: begin
            if (cnt_ff >= QFIXED_LAST) begin
               cnt_in   = '0;
               phase_in = PH_RRFIXED;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_RRFIXED: begin
            if (cnt_ff == '0) begin
               for (int i = 0; i < 16; i++) cand_in[i] = 8'd0;
            end
            if (cnt_ff == RR_TYPE_HI)  kind_in[15:8] = msg_byte;
            if (cnt_ff == RR_TYPE_LO)  kind_in[7:0]  = msg_byte;
            if (cnt_ff == RR_RDLEN_HI) len_in[15:8]  = msg_byte;
            if (cnt_ff == RR_RDLEN_LO) len_in[7:0]   = msg_byte;
            if (cnt_ff >= RRFIXED_LAST) begin
               if (len_new == '0) begin
                  finish = 1'b1;
               end else begin
                  cnt_in   = '0;
                  phase_in = PH_RRDATA;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_RRDATA: begin
            // IPv4 bytes land in the last four lanes of the 16-byte candidate
            if (kind_ff == TYPE_A && cnt_ff < A_DATA_BYTES) begin
               cand_in[{2'b11, cnt_ff[1:0]}] = msg_byte;
            end else if (kind_ff == TYPE_AAAA && cnt_ff < AAAA_DATA_BYTES) begin
               cand_in[cnt_ff[3:0]] = msg_byte;
            end
            if ({1'b0, cnt_ff} + 17'd1 >= {1'b0, len_ff}) begin
               finish = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_DONE: begin
         end
         default: phase_in = PH_DONE;
      endcase

      for (int i = 0; i < 8; i++) begin
         cand_hi[63 - 8*i -: 8] = cand_in[i];
         cand_lo[63 - 8*i -: 8] = cand_in[8 + i];
      end
      cand_v4 = cand_lo[31:0];

      if (finish) begin
         if (kind_ff == TYPE_A) begin
            com_hi_in   = '0;
            com_lo_in   = {V4_MAP_HI, cand_v4};
            com_kind_in = KIND_V4;
         end else if (kind_ff == TYPE_AAAA) begin
            com_hi_in   = cand_hi;
            com_lo_in   = cand_lo;
            com_kind_in = KIND_V6;
         end
         ans_in   = ans_ff - 16'd1;
         cnt_in   = '0;
         phase_in = (ans_ff == 16'd1) ? PH_DONE : PH_RRFIXED;
      end

      result.address_high = com_hi_in;
      result.address_low  = com_lo_in;
      result.found_kind   = com_kind_in;
      result.truncated    = (phase_in != PH_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         // Reset or end of message: back to the header phase for the next one
         phase_ff    <= PH_HEADER;
         cnt_ff      <= '0;
         ans_ff      <= '0;
         kind_ff     <= '0;
         len_ff      <= '0;
         com_hi_ff   <= '0;
         com_lo_ff   <= '0;
         com_kind_ff <= KIND_NONE;
         for (int i = 0; i < 16; i++) cand_ff[i] <= 8'd0;
      end else if (take) begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         ans_ff      <= ans_in;
         kind_ff     <= kind_in;
         len_ff      <= len_in;
         com_hi_ff   <= com_hi_in;
         com_lo_ff   <= com_lo_in;
         com_kind_ff <= com_kind_in;
         cand_ff     <= cand_in;
      end
   end

endmodule

// ----- hw/rtl/dns_answer_address_extractor_top.sv -----
// Top level of the DNS answer address extractor: handshake and result register.
// Depends on dnsa_pkg and dnsa_parser.
//
//   channel  direction  payload                                     transfer
//   req_     in         msg_byte[7:0], last_byte                    req_valid & req_ready
//   rsp_     out        address_high/low[63:0], found_kind, truncated rsp_valid & rsp_ready
//
// One byte per cycle while req_ready is high; the result of a message is registered on the transfer of its
// last byte and shows on rsp_ in the cycle after.
// Non-last bytes are always taken; a last byte waits only while an earlier result
// is still held and rsp_ready is low.
// Synchronous active-high reset returns the parser to the header phase.
`timescale 1ns / 1ps

module dns_answer_address_extractor_top import dnsa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_address_high,
   output logic [63:0] rsp_address_low,
   output logic [1:0]  rsp_found_kind,
   output logic        rsp_truncated
);

   logic       take;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_last_byte;
   assign take      = req_valid && req_ready;

   dnsa_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .msg_byte  (req_msg_byte),
      .last_byte (req_last_byte),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (take && req_last_byte) rsp_ff <= result;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address_high = rsp_ff.address_high;
   assign rsp_address_low  = rsp_ff.address_low;
   assign rsp_found_kind   = rsp_ff.found_kind;
   assign rsp_truncated    = rsp_ff.truncated;

endmodule

// ----- hw/rtl/dnsa_checker.sv -----
// Port-level checks for the DNS answer address extractor, bound to the top level.
// Depends on dnsa_pkg for the address family codes.
`timescale 1ns / 1ps

module dnsa_checker import dnsa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_address_high,
   input logic [63:0] rsp_address_low,
   input logic [1:0]  rsp_found_kind
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address_high)
         && $stable(rsp_address_low) && $stable(rsp_found_kind))
      else $error("result changed while stalled");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no result after last byte");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) && !(req_valid && req_ready && req_last_byte) |=> !rsp_valid)
      else $error("result without a last byte");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_kind == KIND_NONE |->
         rsp_address_high == '0 && rsp_address_low == '0)
      else $error("address present without a record");

   a_v4_mapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_kind == KIND_V4 |->
         rsp_address_high == '0 && rsp_address_low[63:32] == V4_MAP_HI)
      else $error("IPv4 result not mapped");

endmodule

bind dns_answer_address_extractor_top dnsa_checker u_dnsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_address_high (rsp_address_high),
   .rsp_address_low  (rsp_address_low),
   .rsp_found_kind   (rsp_found_kind)
);

// ----- dv/testbench.sv -----
// Testbench for dns_answer_address_extractor_top: streams DNS responses byte by byte
// and checks each extracted address against a predictor kept inside this file.
// Depends on dnsa_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;
   import dnsa_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int PHASE_BYTES   = 180;
   localparam int PHASE_ANSWERS = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_msg_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_address_high;
   logic [63:0] rsp_address_low;
   logic [1:0]  rsp_found_kind;
   logic        rsp_truncated;

   dns_answer_address_extractor_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_msg_byte     (req_msg_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_address_high (rsp_address_high),
      .rsp_address_low  (rsp_address_low),
      .rsp_found_kind   (rsp_found_kind),
      .rsp_truncated    (rsp_truncated)
   );

   always #5 clock = ~clock;

   // Parser shadow state
   phase_type   walk_phase;
   logic [15:0] walk_count;
   logic [15:0] answers_pending;
   logic [15:0] rec_type;
   logic [15:0] rec_len;
   logic [63:0] staged_addr [2];
   logic [63:0] kept_addr [2];
   logic [1:0]  kept_kind;

   result_type  expected_answers [$];
   logic [7:0]  msg_bytes [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int sent_bytes = 0;
   int sent_messages = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   function void reset_walker();
      walk_phase      = PH_HEADER;
      walk_count      = '0;
      answers_pending = '0;
      rec_type        = '0;
      rec_len         = '0;
      staged_addr[0]  = '0;
      staged_addr[1]  = '0;
      kept_addr[0]    = '0;
      kept_addr[1]    = '0;
      kept_kind       = KIND_NONE;
   endfunction

   function void finish_answer();
      if (rec_type == TYPE_A) begin
         kept_addr[0] = '0;
         kept_addr[1] = {V4_MAP_HI, staged_addr[1][31:0]};
         kept_kind    = KIND_V4;
      end else if (rec_type == TYPE_AAAA) begin
         kept_addr[0] = staged_addr[0];
         kept_addr[1] = staged_addr[1];
         kept_kind    = KIND_V6;
      end
      answers_pending = answers_pending - 16'd1;
      walk_count = '0;
      walk_phase = (answers_pending == 0) ? PH_DONE : PH_RRFIXED;
   endfunction

   // Advance the shadow parser by one byte; queue the answer on the last byte.
   function void parse_expected(logic [7:0] value, logic is_last);
      result_type answer;
      case (walk_phase)
         PH_HEADER: begin
            if (walk_count == HDR_ANCOUNT_HI) answers_pending[15:8] = value;
            if (walk_count == HDR_ANCOUNT_LO) answers_pending[7:0] = value;
            if (walk_count >= HDR_LAST) begin
               walk_count = '0;
               walk_phase = (answers_pending == 0) ? PH_DONE : PH_QNAME;
            end else begin
               walk_count = walk_count + 16'd1;
            end
         end
         PH_QNAME: begin
            if (value == 8'h00) begin
               walk_count = '0;
               walk_phase = PH_QFIXED;
            end
         end
         PH_QFIXED: begin
            if (walk_count >= QFIXED_LAST) begin
               walk_count = '0;
               walk_phase = PH_RRFIXED;
            end else begin
               walk_count = walk_count + 16'd1;
            end
         end
         PH_RRFIXED: begin
            if (walk_count == 0) begin
               staged_addr[0] = '0;
               staged_addr[1] = '0;
            end
            if (walk_count == RR_TYPE_HI)  rec_type[15:8] = value;
            if (walk_count == RR_TYPE_LO)  rec_type[7:0]  = value;
            if (walk_count == RR_RDLEN_HI) rec_len[15:8]  = value;
            if (walk_count == RR_RDLEN_LO) rec_len[7:0]   = value;
            if (walk_count >= RRFIXED_LAST) begin
               if (rec_len == 0) begin
                  finish_answer();
               end else begin
                  walk_count = '0;
                  walk_phase = PH_RRDATA;
               end
            end else begin
               walk_count = walk_count + 16'd1;
            end
         end
         PH_RRDATA: begin
            if (rec_type == TYPE_A && walk_count < A_DATA_BYTES) begin
               staged_addr[1] |= 64'(value) << (8 * (3 - int'(walk_count)));
            end else if (rec_type == TYPE_AAAA && walk_count < AAAA_DATA_BYTES) begin
               staged_addr[walk_count[3]] |= 64'(value) << (8 * (7 - int'(walk_count[2:0])));
            end
            if (int'(walk_count) + 1 >= int'(rec_len)) finish_answer();
            else walk_count = walk_count + 16'd1;
         end
         default: walk_phase = PH_DONE;
      endcase
      if (is_last) begin
         answer.address_high = (kept_kind != KIND_NONE) ? kept_addr[0] : 64'd0;
         answer.address_low  = (kept_kind != KIND_NONE) ? kept_addr[1] : 64'd0;
         answer.found_kind   = kept_kind;
         answer.truncated    = (walk_phase != PH_DONE);
         expected_answers.push_back(answer);
         reset_walker();
      end
   endfunction

   // ---------------------------------------------------------------- message building

   task push_word16(input logic [15:0] value);
      msg_bytes.push_back(value[15:8]);
      msg_bytes.push_back(value[7:0]);
   endtask

   task push_random(input int n);
      repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
   endtask

   task push_header(input logic [15:0] answer_count);
      push_random(6);
      push_word16(answer_count);
      push_random(4);
   endtask

   task push_question(input int labels);
      int len;
      repeat (labels) begin
         len = $urandom_range(1, 6);
         msg_bytes.push_back(8'(len));
         repeat (len) msg_bytes.push_back(8'($urandom_range(1, 255)));
      end
      msg_bytes.push_back(8'h00);
      push_random(4);
   endtask

   // fill below zero gives random data bytes
   task push_record(input logic [15:0] kind, input logic [15:0] rdlen, input int ndata,
                    input int fill);
      push_random(2);
      push_word16(kind);
      push_random(6);
      push_word16(rdlen);
      repeat (ndata) begin
         if (fill < 0) msg_bytes.push_back(8'($urandom_range(255)));
         else msg_bytes.push_back(8'(fill));
      end
   endtask

   task cut_message(input int keep);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
   endtask

   // ---------------------------------------------------------------- request side

   task send_byte(input logic [7:0] value, input logic is_last);
      logic took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_msg_byte  <= value;
      req_last_byte <= is_last;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      parse_expected(value, is_last);
      sent_bytes++;
   endtask

   task send_message();
      for (int i = 0; i < msg_bytes.size(); i++) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
      sent_messages++;
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function void report_field(string name, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %h, got %h", name, want, got);
   endfunction

   // Sample on the falling edge ahead of the edge that completes the transfer
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: high %h low %h kind %0d truncated %0b",
                        rsp_address_high, rsp_address_low, rsp_found_kind, rsp_truncated);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_address_high !== want.address_high)
               report_field("address_high", want.address_high, rsp_address_high);
            if (rsp_address_low !== want.address_low)
               report_field("address_low", want.address_low, rsp_address_low);
            if (rsp_found_kind !== want.found_kind)
               report_field("found_kind", 64'(want.found_kind), 64'(rsp_found_kind));
            if (rsp_truncated !== want.truncated)
               report_field("truncated", 64'(want.truncated), 64'(rsp_truncated));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL dns_answer_address_extractor_top");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task test_short_headers();
      // end on the very first byte, all ones and all zeros
      msg_bytes.push_back(8'hFF);
      send_message();
      msg_bytes.push_back(8'h00);
      send_message();
      // zero answers: trailing bytes ignored, not truncated
      push_header(16'h0000);
      push_record(TYPE_A, 16'd4, 4, 8'hFF);
      send_message();
      push_header(16'h0000);
      send_message();
      // end inside the question name, then inside the question type/class
      push_header(16'd2);
      msg_bytes.push_back(8'h03);
      msg_bytes.push_back(8'hFF);
      msg_bytes.push_back(8'h80);
      send_message();
      push_header(16'd1);
      push_question(1);
      cut_message(msg_bytes.size() - 2);
      send_message();
   endtask

   task test_record_types();
      push_header(16'd1);
      push_question(0);
      push_record(TYPE_A, 16'd4, 4, 8'hFF);
      send_message();
      // later AAAA replaces the earlier A
      push_header(16'd2);
      push_question(2);
      push_record(TYPE_A, 16'd4, 4, -1);
      push_record(TYPE_AAAA, 16'd16, 16, 8'hFF);
      send_message();
      // A after AAAA must clear the upper address word
      push_header(16'd2);
      push_question(1);
      push_record(TYPE_AAAA, 16'd16, 16, -1);
      push_record(TYPE_A, 16'd4, 4, -1);
      push_random(5);
      send_message();
      // unknown types skipped by their length
      push_header(16'd2);
      push_question(1);
      push_record(16'hFFFF, 16'd5, 5, -1);
      push_record(TYPE_A, 16'd4, 4, 8'h00);
      send_message();
      push_header(16'd1);
      push_question(1);
      push_record(16'd5, 16'd7, 7, -1);
      send_message();
   endtask

   task test_record_data_lengths();
      push_header(16'd1);
      push_question(1);
      push_record(TYPE_A, 16'd0, 0, 0);
      send_message();
      push_header(16'd2);
      push_question(0);
      push_record(TYPE_A, 16'd2, 2, 8'hFF);
      push_record(TYPE_A, 16'd7, 7, -1);
      send_message();
      push_header(16'd1);
      push_question(1);
      push_record(TYPE_AAAA, 16'd5, 5, -1);
      send_message();
      push_header(16'd1);
      push_question(1);
      push_record(TYPE_AAAA, 16'd20, 20, -1);
      send_message();
   endtask

   task test_cut_messages();
      // complete A, then an AAAA cut inside its data
      push_header(16'd2);
      push_question(1);
      push_record(TYPE_A, 16'd4, 4, -1);
      push_record(TYPE_AAAA, 16'd16, 9, -1);
      send_message();
      // more answers counted than sent
      push_header(16'hFFFF);
      push_question(1);
      push_record(TYPE_AAAA, 16'd16, 16, -1);
      send_message();
      // maximum data length, cut early
      push_header(16'd1);
      push_question(1);
      push_record(TYPE_AAAA, 16'hFFFF, 10, 8'hFF);
      send_message();
      // cut inside the fixed part of a record
      push_header(16'd1);
      push_question(1);
      push_record(TYPE_A, 16'd4, 4, -1);
      cut_message(msg_bytes.size() - 9);
      send_message();
   endtask

   task test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      req_valid <= 1'b0;
      @(negedge clock);
      hold_request = 300;
      @(posedge clock);
      // short messages pile up behind the held result
      repeat (6) begin
         push_random(1);
         send_message();
      end
      repeat (2) begin
         push_header(16'h0000);
         send_message();
      end
   endtask

   task random_record();
      logic [15:0] kind;
      logic [15:0] len;
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         kind = TYPE_A;
         len = ($urandom_range(99) < 70) ? A_DATA_BYTES : 16'($urandom_range(0, 7));
      end else if (pick < 75) begin
         kind = TYPE_AAAA;
         len = ($urandom_range(99) < 70) ? AAAA_DATA_BYTES : 16'($urandom_range(0, 20));
      end else begin
         kind = 16'($urandom);
         len = 16'($urandom_range(0, 12));
      end
      push_record(kind, len, int'(len), -1);
   endtask

   task random_message();
      int pick;
      int count;
      pick = $urandom_range(99);
      if (pick < 10) begin
         push_random($urandom_range(1, 40));
      end else begin
         count = (pick < 15) ? 0 : $urandom_range(1, 3);
         push_header(16'(count));
         push_question($urandom_range(0, 3));
         repeat (count) random_record();
         push_random($urandom_range(0, 3));
         if ($urandom_range(99) < 20) cut_message($urandom_range(1, msg_bytes.size()));
      end
      send_message();
   endtask

   task test_random_traffic();
      int byte_mark;
      int msg_mark;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         byte_mark = sent_bytes;
         msg_mark = sent_messages;
         while (sent_bytes - byte_mark < PHASE_BYTES || sent_messages - msg_mark < PHASE_ANSWERS)
            random_message();
      end
   endtask

   initial begin
      reset_walker();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_short_headers();
      test_record_types();
      test_record_data_lengths();
      test_cut_messages();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS dns_answer_address_extractor_top");
      end else begin
         $display("FAIL dns_answer_address_extractor_top");
      end
      $finish;
   end

endmodule
